// ===== hw/rtl/clipped_sprite_blitter_1bpp_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sprite blitter
// Short forms of the implication properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_SPRITE_BLITTER_1BPP_CORE_MACROS_SVH
`define CLIPPED_SPRITE_BLITTER_1BPP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: property failed");

`endif

// ===== hw/rtl/csblit_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter package
// Screen geometry, derived widths, item codes and the frame memory request.
// ----------------------------------------------------------------------------
package csblit_pkg;

	localparam int SCREEN_PIXELS_WIDE = 128;
	localparam int SCREEN_ROWS        = 64;
	localparam int SPRITE_ROWS        = 8;

	localparam int SPRITE_PIXELS = 8;
	localparam int ROW_BYTES     = SCREEN_PIXELS_WIDE / 8;
	localparam int STORE_BYTES   = SCREEN_ROWS * ROW_BYTES;

	localparam int AW      = $clog2(STORE_BYTES);
	localparam int CW      = $clog2(ROW_BYTES);
	localparam int SROW_W  = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;
	localparam int PROW_W  = $clog2(SCREEN_ROWS + SPRITE_ROWS);
	localparam int S_W     = 19;

	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_VIEW_LEFT = '0;

	localparam logic [1:0] KIND_BLIT  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [7:0]    wr_data;
	} mem_req_t;

endpackage

// ===== hw/rtl/csblit_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csblit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/csblit_apb.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter configuration registers
// APB-style register file holding the camera's left edge.
// ----------------------------------------------------------------------------
module csblit_apb
	import csblit_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [15:0]        view_left
);

	logic [15:0]          view_left_q;
	logic [REG_IDX_W-1:0] reg_idx;

	assign reg_idx   = paddr[PADDR_W-1:2];
	assign pready    = 1'b1;
	assign view_left = view_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_left_q <= '0;
		end else if (psel && penable && pwrite && reg_idx == REG_VIEW_LEFT) begin
			view_left_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_VIEW_LEFT) begin
			prdata = {16'h0000, view_left_q};
		end
	end

endmodule

// ===== hw/rtl/csblit_engine.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter engine
// Sequencer that clears the frame memory, serves byte reads and writes, places
// sprites and walks their rows through a read-modify-write pipeline.
// ----------------------------------------------------------------------------
module csblit_engine
	import csblit_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] view_left,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] sprite_rows,
	input  logic [15:0] world_x,
	input  logic [5:0]  row_y,
	input  logic signed [7:0] nudge,
	input  logic        xor_mode,
	input  logic [9:0]  byte_addr,
	input  logic [7:0]  write_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  read_data,
	output logic        drawn,
	output logic        clipped,
	output mem_req_t    mem_req,
	input  logic [7:0]  mem_rdata
);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_PLACE, ST_GEOM, ST_WALK, ST_RDATA, ST_RESP
	} state_t;

	typedef enum logic [1:0] {PL_FULL, PL_LEFT, PL_RIGHT, PL_OFF} place_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic result_valid_q;
	logic [7:0] read_data_q;
	logic drawn_q;
	logic clipped_q;

	logic [1:0] kind_q;
	logic [63:0] spr_q;
	logic [15:0] wx_q;
	logic [5:0] y_q;
	logic signed [7:0] nudge_q;
	logic xor_q;
	logic [9:0] addr_q;
	logic [7:0] wdata_q;
	logic signed [S_W-1:0] s_q;
	logic cull_q;
	place_t place_q;
	logic [2:0] r_q;
	logic [CW-1:0] col_q;
	logic [SROW_W-1:0] i_q;
	logic half_q;
	logic [PROW_W-1:0] row_q;
	logic [7:0] res_read_q;
	logic res_drawn_q;
	logic res_clip_q;

	logic en_s1;
	logic [AW-1:0] waddr_s1;
	logic [7:0] bits_s1;

	logic accept;
	logic signed [S_W-1:0] s_d;
	logic [16:0] wx_e;
	logic [16:0] cam_e;
	logic cull_d;
	place_t place_d;
	logic geom_draw;
	logic [CW:0] colsel;
	logic slot_en;
	logic [15:0] shifted;
	logic [7:0] slot_bits;
	logic [AW-1:0] slot_addr;
	logic walk_last;
	logic [AW-1:0] item_addr;
	logic in_range;
	logic [7:0] merged;

	assign accept       = item_valid && state_q == ST_IDLE;
	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign read_data    = read_data_q;
	assign drawn        = drawn_q;
	assign clipped      = clipped_q;

	assign wx_e  = {1'b0, wx_q};
	assign cam_e = {1'b0, view_left};
	assign s_d   = signed'({3'b000, wx_q}) - signed'({3'b000, view_left})
		+ S_W'(nudge_q);
	assign cull_d = (wx_e > cam_e + 17'(SCREEN_PIXELS_WIDE))
		|| (wx_e + 17'(SPRITE_PIXELS) < cam_e);

	always_comb begin
		if (!s_q[S_W-1] && s_q <= S_W'(SCREEN_PIXELS_WIDE - SPRITE_PIXELS)) begin
			place_d = PL_FULL;
		end else if (s_q[S_W-1] && s_q > S_W'(-SPRITE_PIXELS)) begin
			place_d = PL_LEFT;
		end else if (!s_q[S_W-1] && s_q < S_W'(SCREEN_PIXELS_WIDE)) begin
			place_d = PL_RIGHT;
		end else begin
			place_d = PL_OFF;
		end
	end

	assign geom_draw = !cull_q && place_d != PL_OFF && 32'(y_q) < SCREEN_ROWS;

	assign colsel    = half_q ? ({1'b0, col_q} + 1'b1) : {1'b0, col_q};
	assign slot_en   = 32'(row_q) < SCREEN_ROWS && 32'(colsel) < ROW_BYTES
		&& (!half_q || place_q == PL_FULL);
	assign shifted   = {spr_q[63:56], 8'h00} >> r_q;
	assign slot_bits = (half_q || place_q == PL_LEFT) ? shifted[7:0] : shifted[15:8];
	assign slot_addr = AW'(32'(row_q) * ROW_BYTES + 32'(colsel));
	assign walk_last = half_q && i_q == SROW_W'(SPRITE_ROWS - 1);

	assign item_addr = AW'(addr_q);
	assign in_range  = 32'(addr_q) < STORE_BYTES;
	assign merged    = xor_q ? (mem_rdata ^ bits_s1) : (mem_rdata | bits_s1);

	always_comb begin
		mem_req = '0;
		if (state_q == ST_CLEAR) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = clr_q;
		end else if (en_s1) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = waddr_s1;
			mem_req.wr_data = merged;
		end else if (state_q == ST_PLACE && kind_q == KIND_WRITE && in_range) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = item_addr;
			mem_req.wr_data = wdata_q;
		end
		if (state_q == ST_PLACE && kind_q == KIND_READ) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = item_addr;
		end else if (state_q == ST_WALK && slot_en) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = slot_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
			read_data_q    <= '0;
			drawn_q        <= 1'b0;
			clipped_q      <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && state_q != ST_RESP) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					case (kind_q)
						KIND_BLIT: state_q <= ST_GEOM;
						KIND_READ: state_q <= ST_RDATA;
						default:   state_q <= ST_RESP;
					endcase
				end
				ST_GEOM: begin
					state_q <= geom_draw ? ST_WALK : ST_RESP;
				end
				ST_WALK: begin
					if (walk_last) begin
						state_q <= ST_RESP;
					end
				end
				ST_RDATA: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						read_data_q    <= res_read_q;
						drawn_q        <= res_drawn_q;
						clipped_q      <= res_clip_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q      <= kind;
			spr_q       <= sprite_rows;
			wx_q        <= world_x;
			y_q         <= row_y;
			nudge_q     <= nudge;
			xor_q       <= xor_mode;
			addr_q      <= byte_addr;
			wdata_q     <= write_data;
			res_read_q  <= '0;
			res_drawn_q <= 1'b0;
			res_clip_q  <= 1'b0;
		end
		case (state_q)
			ST_PLACE: begin
				s_q    <= s_d;
				cull_q <= cull_d;
			end
			ST_GEOM: begin
				place_q     <= place_d;
				res_drawn_q <= geom_draw;
				res_clip_q  <= geom_draw && place_d != PL_FULL;
				r_q         <= s_q[2:0];
				col_q       <= (place_d == PL_LEFT) ? '0 : s_q[3 +: CW];
				i_q         <= '0;
				half_q      <= 1'b0;
				row_q       <= PROW_W'(y_q);
			end
			ST_WALK: begin
				half_q <= !half_q;
				if (half_q) begin
					i_q   <= i_q + 1'b1;
					row_q <= row_q + 1'b1;
					spr_q <= spr_q << 8;
				end
			end
			ST_RDATA: begin
				res_read_q <= in_range ? mem_rdata : 8'h00;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= state_q == ST_WALK && slot_en;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= slot_addr;
		bits_s1  <= slot_bits;
	end

endmodule

// ===== hw/rtl/clipped_sprite_blitter_1bpp_core.sv =====
// ----------------------------------------------------------------------------
// Clipped 1bpp sprite blitter core
// Frame store of single-bit pixels with clipped sprite blits and byte access.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                         Payload
//  item      in         item_valid / item_stall           kind .. write_data
//  result    out        result_valid / result_stall       read_data, drawn, clipped
//  config    in         psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// A blit that draws walks its sprite byte slots one per cycle through the
// frame memory's read port and a merge-and-write stage behind it; a culled
// or off-screen blit goes from its geometry step straight to the result.
// After reset the frame memory is cleared one byte per cycle, all STORE_BYTES
// (1024) bytes, with item_stall high. Items are taken one at a time; a new
// item is accepted while the previous result still waits under result_stall.
// ----------------------------------------------------------------------------
module clipped_sprite_blitter_1bpp_core
	import csblit_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         kind,
	input  logic [63:0]        sprite_rows,
	input  logic [15:0]        world_x,
	input  logic [5:0]         row_y,
	input  logic signed [7:0]  nudge,
	input  logic               xor_mode,
	input  logic [9:0]         byte_addr,
	input  logic [7:0]         write_data,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         read_data,
	output logic               drawn,
	output logic               clipped
);

	logic [15:0] view_left;
	mem_req_t    mem_req;
	logic [7:0]  mem_rdata;

	csblit_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.view_left (view_left)
	);

	csblit_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.view_left    (view_left),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.sprite_rows  (sprite_rows),
		.world_x      (world_x),
		.row_y        (row_y),
		.nudge        (nudge),
		.xor_mode     (xor_mode),
		.byte_addr    (byte_addr),
		.write_data   (write_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.drawn        (drawn),
		.clipped      (clipped),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata)
	);

	csblit_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_frame (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (mem_rdata)
	);

endmodule

// ===== hw/rtl/csblit_checker.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter port checker
// Watches the item and result channels of the core and checks their handshakes and result flags.
// ----------------------------------------------------------------------------
`include "clipped_sprite_blitter_1bpp_core_macros.svh"

module csblit_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] read_data,
	input logic       drawn,
	input logic       clipped
);

	`CSB_ASSERT_NXT(a_accept_busy, clk, arst_n, item_valid && !item_stall, item_stall)
	`CSB_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(read_data) && $stable(drawn) && $stable(clipped))
	`CSB_ASSERT_IMP(a_clip_needs_draw, clk, arst_n, result_valid && clipped, drawn)
	`CSB_ASSERT_IMP(a_blit_no_data, clk, arst_n, result_valid && drawn, read_data == 8'h00)

endmodule

bind clipped_sprite_blitter_1bpp_core csblit_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.read_data    (read_data),
	.drawn        (drawn),
	.clipped      (clipped)
);
